[rtl/rvs_pkg.sv]
`timescale 1ns / 1ps

package rvs_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned REG_IDX_W = 5;

  // opcodes
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_BRANCH = 7'h63;

  // funct3 codes
  localparam logic [2:0] F3_ADDI = 3'd0;
  localparam logic [2:0] F3_SLLI = 3'd1;
  localparam logic [2:0] F3_SW   = 3'd2;
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_BNE  = 3'd1;

  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] idx;
    logic [XLEN-1:0]      val;
  } wb_t;

  typedef struct packed {
    logic [XLEN-1:0]      next_pc;
    logic                 rd_wr;
    logic [REG_IDX_W-1:0] rd;
    logic [XLEN-1:0]      rd_val;
    logic                 st;
    logic [XLEN-1:0]      st_addr;
    logic [XLEN-1:0]      st_data;
  } exec_res_t;

endpackage

[rtl/rvs_regfile.sv]
`timescale 1ns / 1ps

module rvs_regfile import rvs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [REG_IDX_W-1:0] rs1_idx,
  input  logic [REG_IDX_W-1:0] rs2_idx,
  input  wb_t                  wb,
  output logic [XLEN-1:0]      rs1_val,
  output logic [XLEN-1:0]      rs2_val
);

  logic [XLEN-1:0]      mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid_r;
  logic [XLEN-1:0]      rs1_val_r;
  logic [XLEN-1:0]      rs2_val_r;

  // entries not yet written since reset read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wb.en) begin
      valid_r[wb.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wb.en) begin
      mem[wb.idx] <= wb.val;
    end
  end

  // read ports, with bypass of the writeback landing at the same edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (rs1_idx == '0) begin
        rs1_val_r <= '0;
      end else if (wb.en && wb.idx == rs1_idx) begin
        rs1_val_r <= wb.val;
      end else if (valid_r[rs1_idx]) begin
        rs1_val_r <= mem[rs1_idx];
      end else begin
        rs1_val_r <= '0;
      end
      if (rs2_idx == '0) begin
        rs2_val_r <= '0;
      end else if (wb.en && wb.idx == rs2_idx) begin
        rs2_val_r <= wb.val;
      end else if (valid_r[rs2_idx]) begin
        rs2_val_r <= mem[rs2_idx];
      end else begin
        rs2_val_r <= '0;
      end
    end
  end

  assign rs1_val = rs1_val_r;
  assign rs2_val = rs2_val_r;

endmodule

[rtl/rvs_exec.sv]
`timescale 1ns / 1ps

module rvs_exec import rvs_pkg::*; (
  input  logic [XLEN-1:0] instr,
  input  logic [XLEN-1:0] pc,
  input  logic [XLEN-1:0] rs1_val,
  input  logic [XLEN-1:0] rs2_val,
  output exec_res_t       res
);

  logic [6:0]           opcode;
  logic [2:0]           f3;
  logic [REG_IDX_W-1:0] rd;
  logic [XLEN-1:0]      imm_i;
  logic [XLEN-1:0]      imm_s;
  logic [XLEN-1:0]      imm_b;
  logic [XLEN-1:0]      imm_j;
  logic [XLEN-1:0]      imm_u;
  logic [XLEN-1:0]      pc_plus4;
  logic                 wr;
  logic [XLEN-1:0]      val;

  assign opcode   = instr[6:0];
  assign f3       = instr[14:12];
  assign rd       = instr[11:7];
  assign imm_i    = {{20{instr[31]}}, instr[31:20]};
  assign imm_s    = {{20{instr[31]}}, instr[31:25], instr[11:7]};
  assign imm_b    = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
  assign imm_j    = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
  assign imm_u    = {instr[31:12], 12'b0};
  assign pc_plus4 = pc + XLEN'(4);

  always_comb begin
    wr          = 1'b0;
    val         = '0;
    res.next_pc = pc_plus4;
    res.st      = 1'b0;
    res.st_addr = '0;
    res.st_data = '0;
    unique case (opcode)
      OP_AUIPC: begin
        wr  = 1'b1;
        val = pc + imm_u;
      end
      OP_IMM: begin
        if (f3 == F3_ADDI) begin
          wr  = 1'b1;
          val = rs1_val + imm_i;
        end else if (f3 == F3_SLLI) begin
          wr  = 1'b1;
          val = rs1_val << instr[24:20];
        end
      end
      OP_STORE: begin
        if (f3 == F3_SW) begin
          res.st      = 1'b1;
          res.st_addr = rs1_val + imm_s;
          res.st_data = rs2_val;
        end
      end
      OP_REG: begin
        if (f3 == F3_ADD) begin
          wr  = 1'b1;
          val = rs1_val + rs2_val;
        end else if (f3 == F3_SLT) begin
          wr  = 1'b1;
          val = {{(XLEN-1){1'b0}}, $signed(rs1_val) < $signed(rs2_val)};
        end
      end
      OP_JAL: begin
        wr          = 1'b1;
        val         = pc_plus4;
        res.next_pc = pc + imm_j;
      end
      OP_BRANCH: begin
        if (f3 == F3_BNE && rs1_val != rs2_val) begin
          res.next_pc = pc + imm_b;
        end
      end
      default: begin
      end
    endcase
    // writes to x0 are dropped and reported as no writeback
    res.rd_wr  = wr && (rd != '0);
    res.rd     = res.rd_wr ? rd : '0;
    res.rd_val = res.rd_wr ? val : '0;
  end

endmodule

[rtl/rv32i_subset_execute_core.sv]
`timescale 1ns / 1ps

// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+------------------------------------------
// in       | input     | in_valid / in_stall | in_instr_word
// out      | output    | out_valid/out_stall | out_fetch_pc, out_rd_*, out_store_*
// cfg      | input     | cfg_we              | cfg_wdata (start pc, also loads the pc)
//
// one instruction per cycle while out_stall does not hold the result register; the
// register file is read at the input transfer, then execute loads the result register
// the execute step updates pc and register file at the edge it loads the result
// reset clears the pc to zero unless cfg_we loads it, and marks all 32 registers as zero
// out_stall holds the result register, then the instruction register, then in_stall

module rv32i_subset_execute_core import rvs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [XLEN-1:0]      cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [XLEN-1:0]      in_instr_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [XLEN-1:0]      out_fetch_pc,
  output logic                 out_rd_written,
  output logic [REG_IDX_W-1:0] out_rd_index,
  output logic [XLEN-1:0]      out_rd_value,
  output logic                 out_store_valid,
  output logic [XLEN-1:0]      out_store_address,
  output logic [XLEN-1:0]      out_store_data
);

  logic            in_xfer;
  logic            out_free;
  logic            fire;
  logic            ir_v_r;
  logic [XLEN-1:0] ir_r;
  logic [XLEN-1:0] pc_r;
  logic            out_v_r;
  exec_res_t       res;
  exec_res_t       res_r;
  wb_t             wb;
  logic [XLEN-1:0] rs1_val;
  logic [XLEN-1:0] rs2_val;

  assign out_free = !out_v_r || !out_stall;
  assign fire     = ir_v_r && out_free;
  assign in_stall = ir_v_r && !fire;
  assign in_xfer  = in_valid && !in_stall;

  assign wb.en  = fire && res.rd_wr;
  assign wb.idx = res.rd;
  assign wb.val = res.rd_val;

  rvs_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_xfer),
    .rs1_idx (in_instr_word[19:15]),
    .rs2_idx (in_instr_word[24:20]),
    .wb      (wb),
    .rs1_val (rs1_val),
    .rs2_val (rs2_val)
  );

  rvs_exec u_exec (
    .instr   (ir_r),
    .pc      (pc_r),
    .rs1_val (rs1_val),
    .rs2_val (rs2_val),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      pc_r    <= cfg_we ? cfg_wdata : '0;
    end else begin
      if (in_xfer) begin
        ir_v_r <= 1'b1;
      end else if (fire) begin
        ir_v_r <= 1'b0;
      end
      if (fire) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
      priority if (cfg_we) begin
        pc_r <= cfg_wdata;
      end else if (fire) begin
        pc_r <= res.next_pc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ir_r <= in_instr_word;
    end
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_v_r;
  assign out_fetch_pc      = res_r.next_pc;
  assign out_rd_written    = res_r.rd_wr;
  assign out_rd_index      = res_r.rd;
  assign out_rd_value      = res_r.rd_val;
  assign out_store_valid   = res_r.st;
  assign out_store_address = res_r.st_addr;
  assign out_store_data    = res_r.st_data;

  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    wb.en |-> wb.idx != '0)
    else $error("writeback to x0");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("executed instruction produced no result");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ir_v_r && out_v_r && out_stall)
    else $error("input stalled without a held item");

  a_no_wb_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rd_written) |-> (out_rd_index == '0 && out_rd_value == '0))
    else $error("writeback fields set without a writeback");

endmodule
